// File: sv/mlpq_pkg.sv
// Shared constants, status codes and sequencer state type for the priority queue.
package mlpq_pkg;

  localparam int NUM_LEVELS_DEF = 32;
  localparam int NUM_NODES_DEF  = 64;

  localparam int ID_W  = 6;
  localparam int PRI_W = 6;
  localparam int STS_W = 2;
  localparam int OCC_W = 7;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STS_W-1:0] STS_NO_NODE = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD_PRI = 2'd3;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_DEQ_SCAN,
    ST_DEQ_RD,
    ST_DEQ_WR,
    ST_FIN
  } state_t;

endpackage

// File: sv/multilevel_fifo_priority_queue_unit.sv
// Multilevel priority queue: per-level linked FIFOs over a shared node pool.
// Enqueue: after acceptance, link/tail read, update, then result load.
// Dequeue: a level scan checks one level per cycle, then head read, update, result load.
// Rejected items (bad priority, no free node, empty queue) go straight to the result load.
// One item at a time; in_ready rises the cycle after the result loads; a waiting result holds it.
// Reset (rst, synchronous): levels empty, pool fully free; no clearing pass.
module multilevel_fifo_priority_queue_unit #(
  parameter int NUM_LEVELS = mlpq_pkg::NUM_LEVELS_DEF,
  parameter int NUM_NODES  = mlpq_pkg::NUM_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [mlpq_pkg::ID_W-1:0]   proc_id,
  input  logic [mlpq_pkg::PRI_W-1:0]  priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        got_proc,
  output logic [mlpq_pkg::ID_W-1:0]   out_proc_id,
  output logic [mlpq_pkg::STS_W-1:0]  status,
  output logic [mlpq_pkg::OCC_W-1:0]  occupancy
);

  import mlpq_pkg::*;

  localparam int NW = $clog2(NUM_NODES);
  localparam int CW = $clog2(NUM_NODES + 1);
  localparam int LW = $clog2(NUM_LEVELS);

  state_t state, state_next;

  logic             cmd_r;
  logic [ID_W-1:0]  pid_r;
  logic [PRI_W-1:0] pri_r;
  logic [LW-1:0]    lvl;

  logic [NUM_LEVELS-1:0] nonempty;
  logic [NW-1:0]         rec_head;
  logic [CW-1:0]         rec_cnt;
  logic [CW-1:0]         fresh;
  logic [CW-1:0]         total;

  logic              res_got;
  logic [ID_W-1:0]   res_id;
  logic [STS_W-1:0]  res_sts;

  logic [NW-1:0]   head_q, tail_q, link_q;
  logic [ID_W-1:0] handle_q;

  logic [LW-1:0]   lvl_addr;
  logic [NW-1:0]   link_raddr;
  logic [NW-1:0]   alloc;
  logic            have_rec;
  logic            have_free;
  logic            bad_pri;
  logic            out_free;
  logic [CW+OCC_W-1:0] total_ext;

  logic            head_we, tail_we, link_we, handle_we;
  logic [NW-1:0]   head_wdata, link_waddr, link_wdata;

  assign have_rec   = (rec_cnt != '0);
  assign have_free  = have_rec || (fresh != CW'(NUM_NODES));
  assign bad_pri    = ({1'b0, priority_req} >= 7'(NUM_LEVELS));
  assign alloc      = have_rec ? rec_head : fresh[NW-1:0];
  assign lvl_addr   = (cmd_r == CMD_DEQ) ? lvl : pri_r[LW-1:0];
  assign link_raddr = (cmd_r == CMD_DEQ) ? head_q : rec_head;
  assign out_free   = !out_valid || out_ready;
  assign total_ext  = {{OCC_W{1'b0}}, total};
  assign in_ready   = (state == ST_IDLE);

  mlpq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(NW)) u_head (
    .clk(clk), .we(head_we), .waddr(lvl_addr), .wdata(head_wdata),
    .raddr(lvl_addr), .rdata(head_q)
  );

  mlpq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(NW)) u_tail (
    .clk(clk), .we(tail_we), .waddr(lvl_addr), .wdata(alloc),
    .raddr(lvl_addr), .rdata(tail_q)
  );

  mlpq_ram #(.DEPTH(NUM_NODES), .WIDTH(NW)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_q)
  );

  mlpq_ram #(.DEPTH(NUM_NODES), .WIDTH(ID_W)) u_handle (
    .clk(clk), .we(handle_we), .waddr(alloc), .wdata(pid_r),
    .raddr(head_q), .rdata(handle_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_DEQ) begin
            state_next = (total == '0) ? ST_FIN : ST_DEQ_SCAN;
          end else if (bad_pri || !have_free) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_ENQ_RD;
          end
        end
      end
      ST_ENQ_RD:   state_next = ST_ENQ_WR;
      ST_ENQ_WR:   state_next = ST_FIN;
      ST_DEQ_SCAN: if (nonempty[lvl]) state_next = ST_DEQ_RD;
      ST_DEQ_RD:   state_next = ST_DEQ_WR;
      ST_DEQ_WR:   state_next = ST_FIN;
      ST_FIN:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_we    = 1'b0;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    handle_we  = 1'b0;
    head_wdata = alloc;
    link_waddr = tail_q;
    link_wdata = alloc;
    unique case (state)
      ST_ENQ_WR: begin
        handle_we = 1'b1;
        tail_we   = 1'b1;
        head_we   = !nonempty[lvl_addr];
        link_we   = nonempty[lvl_addr];
      end
      ST_DEQ_WR: begin
        head_we    = (head_q != tail_q);
        head_wdata = link_q;
        link_we    = 1'b1;
        link_waddr = head_q;
        link_wdata = rec_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nonempty  <= '0;
      rec_head  <= '0;
      rec_cnt   <= '0;
      fresh     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd;
            pid_r   <= proc_id;
            pri_r   <= priority_req;
            lvl     <= '0;
            res_got <= 1'b0;
            res_id  <= '0;
            if (cmd == CMD_DEQ) begin
              res_sts <= (total == '0) ? STS_EMPTY : STS_OK;
            end else if (bad_pri) begin
              res_sts <= STS_BAD_PRI;
            end else if (!have_free) begin
              res_sts <= STS_NO_NODE;
            end else begin
              res_sts <= STS_OK;
            end
          end
        end
        ST_ENQ_WR: begin
          nonempty[lvl_addr] <= 1'b1;
          if (have_rec) begin
            rec_head <= link_q;
            rec_cnt  <= rec_cnt - 1'b1;
          end else begin
            fresh <= fresh + 1'b1;
          end
          total <= total + 1'b1;
        end
        ST_DEQ_SCAN: begin
          if (!nonempty[lvl]) begin
            lvl <= lvl + 1'b1;
          end
        end
        ST_DEQ_WR: begin
          if (head_q == tail_q) begin
            nonempty[lvl] <= 1'b0;
          end
          rec_head <= head_q;
          rec_cnt  <= rec_cnt + 1'b1;
          total    <= total - 1'b1;
          res_got  <= 1'b1;
          res_id   <= handle_q;
        end
        ST_FIN: begin
          if (out_free) begin
            got_proc    <= res_got;
            out_proc_id <= res_id;
            status      <= res_sts;
            occupancy   <= total_ext[OCC_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/mlpq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module mlpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/multilevel_fifo_priority_queue_unit_tb.sv
// Testbench for the multilevel priority queue: directed and random traffic against a level-FIFO scoreboard.
`timescale 1ns / 100ps

module multilevel_fifo_priority_queue_unit_tb;
  import mlpq_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 482;
  localparam int LVL_W       = $clog2(NUM_LEVELS_DEF);

  typedef struct {
    logic             got_proc;
    logic [ID_W-1:0]  proc_id;
    logic [STS_W-1:0] status;
    logic [OCC_W-1:0] occupancy;
  } pq_result_t;

  class pq_scoreboard;
    logic [ID_W-1:0] level_fifo[NUM_LEVELS_DEF][$];
    int              queued;
    pq_result_t      expected_q[$];
    int              errors;
    int              n_enq, n_deq_ok, n_empty, n_no_node, n_bad_pri, n_checked, peak_occ;

    function void note_input(logic c, logic [ID_W-1:0] pid, logic [PRI_W-1:0] pri);
      pq_result_t e;
      e.got_proc = 1'b0;
      e.proc_id  = '0;
      e.status   = STS_OK;
      if (c == CMD_ENQ) begin
        if (pri >= NUM_LEVELS_DEF) begin
          e.status = STS_BAD_PRI;
          n_bad_pri++;
        end else if (queued == NUM_NODES_DEF) begin
          e.status = STS_NO_NODE;
          n_no_node++;
        end else begin
          level_fifo[pri[LVL_W-1:0]].push_back(pid);
          queued++;
          n_enq++;
        end
      end else begin
        e.status = STS_EMPTY;
        for (int lv = 0; lv < NUM_LEVELS_DEF; lv++) begin
          if (level_fifo[lv].size() != 0) begin
            e.got_proc = 1'b1;
            e.proc_id  = level_fifo[lv].pop_front();
            e.status   = STS_OK;
            queued--;
            break;
          end
        end
        if (e.got_proc) n_deq_ok++;
        else n_empty++;
      end
      if (queued > peak_occ) peak_occ = queued;
      e.occupancy = queued[OCC_W-1:0];
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic got, logic [ID_W-1:0] pid, logic [STS_W-1:0] sts,
                               logic [OCC_W-1:0] occ);
      pq_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual got=%0d id=%0d sts=%0d occ=%0d",
                 $time, got, pid, sts, occ);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      compare_field("got_proc", int'(e.got_proc), int'(got));
      compare_field("out_proc_id", int'(e.proc_id), int'(pid));
      compare_field("status", int'(e.status), int'(sts));
      compare_field("occupancy", int'(e.occupancy), int'(occ));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             cmd = CMD_ENQ;
  logic [ID_W-1:0]  proc_id = '0;
  logic [PRI_W-1:0] priority_req = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             got_proc;
  logic [ID_W-1:0]  out_proc_id;
  logic [STS_W-1:0] status;
  logic [OCC_W-1:0] occupancy;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  pq_scoreboard sb = new();

  multilevel_fifo_priority_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .proc_id(proc_id),
    .priority_req(priority_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .got_proc(got_proc),
    .out_proc_id(out_proc_id),
    .status(status),
    .occupancy(occupancy)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(got_proc, out_proc_id, status, occupancy);
  end

  task automatic send_item(logic c, logic [ID_W-1:0] pid, logic [PRI_W-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    proc_id      <= pid;
    priority_req <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(c, pid, pri);
  endtask

  task automatic send_random(int enq_pct, bit narrow);
    logic             c;
    logic [PRI_W-1:0] pri;
    int               r;
    c = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    r = $urandom_range(99);
    if (r < 6) pri = PRI_W'($urandom_range(63, NUM_LEVELS_DEF));
    else if (narrow) pri = PRI_W'($urandom_range(3));
    else pri = PRI_W'($urandom_range(NUM_LEVELS_DEF - 1));
    send_item(c, ID_W'($urandom_range(63)), pri);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
    int sent;
    int burst;
    int enq_pct;
    bit narrow;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    if (with_hold) begin
      hold_tog <= ~hold_tog;
      repeat (30) send_random(70, 0);
      sent = 30;
    end
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(120, 30);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      narrow = ($urandom_range(3) == 0);
      for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
        send_random(enq_pct, narrow);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_ENQ, 6'd63, 6'd32);
    send_item(CMD_ENQ, 6'd0, 6'd63);
    send_item(CMD_ENQ, 6'd0, 6'd31);
    send_item(CMD_ENQ, 6'd63, 6'd0);
    send_item(CMD_ENQ, 6'd21, 6'd31);
    send_item(CMD_ENQ, 6'd42, 6'd0);
    send_item(CMD_ENQ, 6'd5, 6'd16);
    send_item(CMD_DEQ, 6'd63, 6'd63);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_ENQ, 6'd17, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_ENQ, 6'd42, 6'd1);
    send_item(CMD_ENQ, 6'd21, 6'd1);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    send_item(CMD_DEQ, 6'd0, 6'd0);
    wait_drained();

    run_phase(0, 0, 1);
    run_phase(78, 0, 0);
    run_phase(0, 78, 0);
    run_phase(8, 8, 0);

    repeat (60) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Checked %0d results: %0d enqueues, %0d dequeues, %0d empty, %0d pool full,",
             sb.n_checked, sb.n_enq, sb.n_deq_ok, sb.n_empty, sb.n_no_node);
    $display("%0d bad priority; peak occupancy %0d; %0d mismatches",
             sb.n_bad_pri, sb.peak_occ, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: multilevel_fifo_priority_queue_unit.f
sv/mlpq_pkg.sv
sv/mlpq_ram.sv
sv/multilevel_fifo_priority_queue_unit.sv
tb/multilevel_fifo_priority_queue_unit_tb.sv
